@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the spherical inversion core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define SIT_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// pre at an edge implies post at the same edge
`define SIT_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// pre at an edge implies post at the next edge
`define SIT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/sit_pkg.sv @@
// Types, constants and saturation helpers of the spherical inversion core
package sit_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned FRAC_W     = 20;
   localparam int unsigned RR_W       = 64;
   localparam int unsigned QUO_W      = 32;
   localparam int unsigned RSQ_SHIFT  = 16;
   localparam int unsigned DNUM_SHIFT = 4;
   localparam int unsigned CNUM_W     = RR_W + FRAC_W;
   localparam int unsigned DPROD_W    = RR_W + 1 + DATA_W;
   localparam int unsigned DNUM_W     = DPROD_W + DNUM_SHIFT;
   localparam int unsigned MAG_W      = RR_W - 1 - FRAC_W;
   localparam int unsigned SQRT_STEPS = RR_W / 2;
   localparam int unsigned DIV_LAT    = QUO_W + 1;
   localparam int unsigned CSR_IDX_W  = 3;

   localparam logic [DATA_W-1:0] ONE     = 32'h0010_0000;
   localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

   // stage numbers: index k names item pipeline register k, counted from the input register
   localparam int unsigned ST_RR    = 3;
   localparam int unsigned ST_ROOT  = ST_RR + SQRT_STEPS;
   localparam int unsigned ST_CQ    = ST_RR + DIV_LAT;
   localparam int unsigned ST_POST  = ST_CQ + 1;
   localparam int unsigned ST_DPROD = ST_ROOT + 1;
   localparam int unsigned ST_DT    = ST_DPROD + 1;
   localparam int unsigned ST_DPART = ST_DT + 1;
   localparam int unsigned ST_DNUM  = ST_DPART + 1;
   localparam int unsigned ST_DQ    = ST_DNUM + DIV_LAT;
   localparam int unsigned ST_SCALE = ST_DQ + 1;
   localparam int unsigned LATENCY  = ST_SCALE + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PRE_X       = 3'd0,
      REG_PRE_Y       = 3'd1,
      REG_PRE_Z       = 3'd2,
      REG_POST_X      = 3'd3,
      REG_POST_Y      = 3'd4,
      REG_POST_Z      = 3'd5,
      REG_RADIUS_SQ   = 3'd6,
      REG_FINAL_SCALE = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              sat;
   } sat_word_type;

   typedef struct packed {
      logic                   valid;
      logic                   apply;
      logic                   sat;
      logic                   rrz;
      logic [RR_W-1:0]        rr;
      logic [2:0][DATA_W-1:0] pt;
      logic [DATA_W-1:0]      de;
   } item_type;

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 32'd1) : v;
   endfunction

   function automatic sat_word_type add_sat(input logic [DATA_W-1:0] a,
                                            input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      sat_word_type    r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         r.sat = 1'b1;
         r.val = s[DATA_W] ? NEG_MAX : POS_MAX;
      end else begin
         r.sat = 1'b0;
         r.val = s[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic sat_word_type sat_signed(input logic neg,
                                               input logic [MAG_W-1:0] m);
      sat_word_type r;
      if (!neg) begin
         if (|m[MAG_W-1:DATA_W-1]) begin
            r.sat = 1'b1;
            r.val = POS_MAX;
         end else begin
            r.sat = 1'b0;
            r.val = m[DATA_W-1:0];
         end
      end else begin
         if ((|m[MAG_W-1:DATA_W]) || (m[DATA_W-1] && (|m[DATA_W-2:0]))) begin
            r.sat = 1'b1;
            r.val = NEG_MAX;
         end else begin
            r.sat = 1'b0;
            r.val = ~m[DATA_W-1:0] + 32'd1;
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/core/spherical_inversion_transform.sv @@
// Top level of the spherical inversion core: pre-offset, inversion, post-offset, de update, scale
//
// One word enters per clock and busy never rises; each result is marked by rsp_strobe for
// one cycle, and results leave in input order. The longest path is the derivative path:
// three input stages, a 32-stage square root of |p|^2, four multiply and add stages, a
// 33-stage divider, a scale stage and the output register; the three coordinate dividers
// run beside the square root.
// Results cannot be held off, so the consumer must take every strobed word. Registers
// are written through csr_we/csr_index/csr_wdata and must only change while no word is
// in flight.
`include "assert_macros.svh"

module spherical_inversion_transform (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sit_pkg::DATA_W-1:0]      req_in_x,
   input  logic [sit_pkg::DATA_W-1:0]      req_in_y,
   input  logic [sit_pkg::DATA_W-1:0]      req_in_z,
   input  logic [sit_pkg::DATA_W-1:0]      req_in_de,
   input  logic                            req_apply,
   output logic                            rsp_strobe,
   output logic [sit_pkg::DATA_W-1:0]      rsp_out_x,
   output logic [sit_pkg::DATA_W-1:0]      rsp_out_y,
   output logic [sit_pkg::DATA_W-1:0]      rsp_out_z,
   output logic [sit_pkg::DATA_W-1:0]      rsp_out_de,
   output logic                            rsp_saturated,
   input  logic                            csr_we,
   input  logic [sit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sit_pkg::DATA_W-1:0]      csr_wdata
);

   localparam int unsigned DW   = sit_pkg::DATA_W;
   localparam int unsigned RW   = sit_pkg::RR_W;
   localparam int unsigned FW   = sit_pkg::FRAC_W;
   localparam int unsigned QW   = sit_pkg::QUO_W;
   localparam int unsigned MW   = sit_pkg::MAG_W;
   localparam int unsigned PW   = sit_pkg::DPROD_W;
   localparam int unsigned LAST = sit_pkg::ST_SCALE;
   localparam int unsigned LAT  = sit_pkg::LATENCY;

   // configuration
   logic [2:0][DW-1:0] pre_ff;
   logic [2:0][DW-1:0] post_ff;
   logic [DW-1:0]      rsq_ff;
   logic [DW-1:0]      fsc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff  <= '0;
         post_ff <= '0;
         rsq_ff  <= sit_pkg::ONE;
         fsc_ff  <= sit_pkg::ONE;
      end else if (csr_we) begin
         case (sit_pkg::csr_reg_type'(csr_index))
            sit_pkg::REG_PRE_X:       pre_ff[0]  <= csr_wdata;
            sit_pkg::REG_PRE_Y:       pre_ff[1]  <= csr_wdata;
            sit_pkg::REG_PRE_Z:       pre_ff[2]  <= csr_wdata;
            sit_pkg::REG_POST_X:      post_ff[0] <= csr_wdata;
            sit_pkg::REG_POST_Y:      post_ff[1] <= csr_wdata;
            sit_pkg::REG_POST_Z:      post_ff[2] <= csr_wdata;
            sit_pkg::REG_RADIUS_SQ:   rsq_ff     <= csr_wdata;
            sit_pkg::REG_FINAL_SCALE: fsc_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // item pipeline
   sit_pkg::item_type pipe_ff [1:LAST];
   sit_pkg::item_type pipe_in [1:LAST];

   logic [2:0][DW-1:0]            req_pt;
   sit_pkg::sat_word_type [2:0]   pre_sum;
   logic [2:0]                    pre_hit;

   assign req_pt = {req_in_z, req_in_y, req_in_x};

   for (genvar i = 0; i < 3; i++) begin : g_pre
      assign pre_sum[i] = sit_pkg::add_sat(req_pt[i], pre_ff[i]);
      assign pre_hit[i] = pre_sum[i].sat;
   end

   always_comb begin
      pipe_in[1].valid = start & ~busy;
      pipe_in[1].apply = req_apply;
      pipe_in[1].sat   = req_apply & (|pre_hit);
      pipe_in[1].rrz   = 1'b0;
      pipe_in[1].rr    = '0;
      pipe_in[1].de    = req_in_de;
      pipe_in[1].pt[0] = req_apply ? pre_sum[0].val : req_pt[0];
      pipe_in[1].pt[1] = req_apply ? pre_sum[1].val : req_pt[1];
      pipe_in[1].pt[2] = req_apply ? pre_sum[2].val : req_pt[2];
   end

   // squares and coordinate numerators
   logic [RW-1:0] sq_ff  [3];
   logic [RW-1:0] sq_in  [3];
   logic [RW-1:0] nm_ff  [3];
   logic [RW-1:0] nm_in  [3];
   logic [RW-1:0] nm3_ff [3];
   logic [RW-1:0] rr_sum;

   for (genvar i = 0; i < 3; i++) begin : g_sq
      logic [DW-1:0] m;
      assign m        = sit_pkg::mag32(pipe_ff[1].pt[i]);
      assign sq_in[i] = RW'(m) * RW'(m);
      assign nm_in[i] = RW'(m) * RW'(rsq_ff);
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      nm_ff  <= nm_in;
      nm3_ff <= nm_ff;
   end

   assign rr_sum = sq_ff[0] + sq_ff[1] + sq_ff[2];

   // coordinate dividers and root
   logic [2:0][QW-1:0] cq_quo;
   logic [2:0]         cq_ovf;
   logic [DW-1:0]      root;

   for (genvar i = 0; i < 3; i++) begin : g_cdiv
      sit_div #(
         .NUM_W (sit_pkg::CNUM_W)
      ) u_cdiv (
         .clock (clock),
         .num_i ({nm3_ff[i], {FW{1'b0}}}),
         .den_i (pipe_ff[sit_pkg::ST_RR].rr),
         .quo_o (cq_quo[i]),
         .ovf_o (cq_ovf[i])
      );
   end

   sit_sqrt u_sqrt (
      .clock  (clock),
      .rr_i   (pipe_ff[sit_pkg::ST_RR].rr),
      .root_o (root)
   );

   // post-offset
   sit_pkg::sat_word_type [2:0] post_cq;
   sit_pkg::sat_word_type [2:0] post_sum;
   logic [2:0]                  post_hit;

   for (genvar i = 0; i < 3; i++) begin : g_post
      assign post_cq[i]  = sit_pkg::sat_signed(pipe_ff[sit_pkg::ST_CQ].pt[i][DW-1],
                              {{(MW-QW-1){1'b0}}, cq_ovf[i], cq_quo[i]});
      assign post_sum[i] = sit_pkg::add_sat(post_cq[i].val, post_ff[i]);
      assign post_hit[i] = post_cq[i].sat | post_sum[i].sat;
   end

   // derivative numerator
   logic [RW-1:0] prod_ff;
   logic [RW:0]   t_ff;
   logic [RW-1:0] pl_ff;
   logic [RW-1:0] ph_ff;
   logic          t64_ff;
   logic [PW-1:0] dsum;
   logic [sit_pkg::DNUM_W-1:0] dnum_ff;
   logic [DW-1:0] de_part;

   assign de_part = pipe_ff[sit_pkg::ST_DPART].de;
   assign dsum = {{(PW-RW){1'b0}}, pl_ff}
               + {{(PW-RW-DW){1'b0}}, ph_ff, {DW{1'b0}}}
               + {1'b0, (t64_ff ? de_part : {DW{1'b0}}), {RW{1'b0}}};

   always_ff @(posedge clock) begin
      prod_ff <= RW'(root) * RW'(pipe_ff[sit_pkg::ST_ROOT].de);
      t_ff    <= {1'b0, prod_ff}
               + {{(RW+1-DW-sit_pkg::RSQ_SHIFT){1'b0}}, rsq_ff,
                  {sit_pkg::RSQ_SHIFT{1'b0}}};
      pl_ff   <= RW'(t_ff[DW-1:0]) * RW'(pipe_ff[sit_pkg::ST_DT].de);
      ph_ff   <= RW'(t_ff[RW-1:DW]) * RW'(pipe_ff[sit_pkg::ST_DT].de);
      t64_ff  <= t_ff[RW];
      dnum_ff <= {dsum, {sit_pkg::DNUM_SHIFT{1'b0}}};
   end

   logic [QW-1:0] dq_quo;
   logic          dq_ovf;

   sit_div #(
      .NUM_W (sit_pkg::DNUM_W)
   ) u_ddiv (
      .clock (clock),
      .num_i (dnum_ff),
      .den_i (pipe_ff[sit_pkg::ST_DNUM].rr),
      .quo_o (dq_quo),
      .ovf_o (dq_ovf)
   );

   // final scale products
   logic [DW-1:0] fmag;
   logic [RW-1:0] mx_ff [3];
   logic [RW-1:0] mx_in [3];
   logic [RW-1:0] md_ff;
   logic [RW-1:0] md_in;

   assign fmag = sit_pkg::mag32(fsc_ff);

   for (genvar i = 0; i < 3; i++) begin : g_scale
      assign mx_in[i] = RW'(sit_pkg::mag32(pipe_ff[sit_pkg::ST_DQ].pt[i])) * RW'(fmag);
   end
   assign md_in = RW'(dq_ovf ? {QW{1'b1}} : dq_quo) * RW'(fmag);

   always_ff @(posedge clock) begin
      mx_ff <= mx_in;
      md_ff <= md_in;
   end

   // advance the item pipeline
   for (genvar k = 2; k <= LAST; k++) begin : g_pipe
      if (k == sit_pkg::ST_RR) begin : g_rr
         always_comb begin
            pipe_in[k]     = pipe_ff[k-1];
            pipe_in[k].rr  = rr_sum;
            pipe_in[k].rrz = ~|rr_sum;
         end
      end else if (k == sit_pkg::ST_POST) begin : g_post_st
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            if (pipe_ff[k-1].apply) begin
               pipe_in[k].pt[0] = post_sum[0].val;
               pipe_in[k].pt[1] = post_sum[1].val;
               pipe_in[k].pt[2] = post_sum[2].val;
               pipe_in[k].sat   = pipe_ff[k-1].sat | (|post_hit);
            end
         end
      end else if (k == sit_pkg::ST_SCALE) begin : g_scale_st
         always_comb begin
            pipe_in[k]     = pipe_ff[k-1];
            pipe_in[k].sat = pipe_ff[k-1].sat | (pipe_ff[k-1].apply & dq_ovf);
         end
      end else begin : g_move
         assign pipe_in[k] = pipe_ff[k-1];
      end
   end

   for (genvar k = 1; k <= LAST; k++) begin : g_pipe_ff
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[k].valid <= 1'b0;
         end else begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // result stage
   sit_pkg::item_type           last;
   sit_pkg::sat_word_type [2:0] scl;
   logic [2:0]                  scl_hit;
   logic [MW-1:0]               dm;
   logic [2:0][DW-1:0]          out_pt_in;
   logic [DW-1:0]               out_de_in;
   logic                        out_sat_in;
   logic [DW-1:0]               de_fin;
   logic                        de_hit;

   assign last = pipe_ff[LAST];
   assign dm   = md_ff[RW-2:FW];

   for (genvar i = 0; i < 3; i++) begin : g_fin
      assign scl[i]     = sit_pkg::sat_signed(last.pt[i][DW-1] ^ fsc_ff[DW-1],
                                              mx_ff[i][RW-2:FW]);
      assign scl_hit[i] = scl[i].sat;
   end

   always_comb begin
      de_fin = dm[DW-1:0];
      de_hit = 1'b0;
      if (fsc_ff[DW-1] && (|dm)) begin
         de_fin = '0;
         de_hit = 1'b1;
      end else if (|dm[MW-1:DW]) begin
         de_fin = '1;
         de_hit = 1'b1;
      end
   end

   always_comb begin
      if (!last.apply) begin
         out_pt_in  = last.pt;
         out_de_in  = last.de;
         out_sat_in = 1'b0;
      end else if (last.rrz) begin
         out_pt_in  = {sit_pkg::POS_MAX, sit_pkg::POS_MAX, sit_pkg::POS_MAX};
         out_de_in  = '1;
         out_sat_in = 1'b1;
      end else begin
         out_pt_in  = {scl[2].val, scl[1].val, scl[0].val};
         out_de_in  = de_fin;
         out_sat_in = last.sat | (|scl_hit) | de_hit;
      end
   end

   logic               rsp_strobe_ff;
   logic [2:0][DW-1:0] rsp_pt_ff;
   logic [DW-1:0]      rsp_de_ff;
   logic               rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pt_ff  <= out_pt_in;
      rsp_de_ff  <= out_de_in;
      rsp_sat_ff <= out_sat_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_x     = rsp_pt_ff[0];
   assign rsp_out_y     = rsp_pt_ff[1];
   assign rsp_out_z     = rsp_pt_ff[2];
   assign rsp_out_de    = rsp_de_ff;
   assign rsp_saturated = rsp_sat_ff;

   logic word_taken;
   logic zero_hit;
   logic zero_out;
   logic pass_hit;

   assign word_taken = start & ~busy;
   assign zero_hit   = last.valid & last.apply & last.rrz;
   assign zero_out   = rsp_strobe & rsp_saturated & (&rsp_out_de);
   assign pass_hit   = last.valid & ~last.apply;

   `SIT_ASSERT_IMPL(a_strobe_has_word, rsp_strobe, $past(word_taken, LAT), "stray result")
   `SIT_ASSERT_NEXT(a_zero_radius, zero_hit, zero_out, "zero radius not saturated")
   `SIT_ASSERT_NEXT(a_pass_clean, pass_hit, rsp_strobe && !rsp_saturated, "pass word flagged")

endmodule

@@ rtl/core/sit_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
module sit_div #(
   parameter int unsigned NUM_W = sit_pkg::CNUM_W
) (
   input  logic                       clock,
   input  logic [NUM_W-1:0]           num_i,
   input  logic [sit_pkg::RR_W-1:0]   den_i,
   output logic [sit_pkg::QUO_W-1:0]  quo_o,
   output logic                       ovf_o
);

   localparam int unsigned QW    = sit_pkg::QUO_W;
   localparam int unsigned DW    = sit_pkg::RR_W;
   localparam int unsigned TOP_W = NUM_W - QW;
   localparam int unsigned CMP_W = (TOP_W > DW) ? TOP_W : DW;

   logic [DW-1:0] rem_ff [0:QW];
   logic [DW-1:0] rem_in [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [QW-1:0] low_in [0:QW];
   logic [QW-1:0] quo_ff [0:QW];
   logic [QW-1:0] quo_in [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic [DW-1:0] den_in [0:QW];
   logic          ovf_ff [0:QW];
   logic          ovf_in [0:QW];

   logic [TOP_W-1:0] top;
   logic             ovf0;

   assign top  = num_i[NUM_W-1:QW];
   assign ovf0 = CMP_W'(top) >= CMP_W'(den_i);

   assign rem_in[0] = ovf0 ? '0 : DW'(top);
   assign low_in[0] = num_i[QW-1:0];
   assign quo_in[0] = '0;
   assign den_in[0] = den_i;
   assign ovf_in[0] = ovf0;

   for (genvar s = 1; s <= QW; s++) begin : g_step
      logic [DW:0]   trial;
      logic [DW+1:0] diff;
      assign trial     = {rem_ff[s-1], low_ff[s-1][QW-1]};
      assign diff      = {1'b0, trial} - {2'b0, den_ff[s-1]};
      assign rem_in[s] = diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
      assign quo_in[s] = {quo_ff[s-1][QW-2:0], ~diff[DW+1]};
      assign low_in[s] = {low_ff[s-1][QW-2:0], 1'b0};
      assign den_in[s] = den_ff[s-1];
      assign ovf_in[s] = ovf_ff[s-1];
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      ovf_ff <= ovf_in;
   end

   assign quo_o = quo_ff[QW];
   assign ovf_o = ovf_ff[QW];

endmodule

@@ rtl/core/sit_sqrt.sv @@
// Pipelined integer square root, one root bit per stage
module sit_sqrt (
   input  logic                        clock,
   input  logic [sit_pkg::RR_W-1:0]    rr_i,
   output logic [sit_pkg::DATA_W-1:0]  root_o
);

   localparam int unsigned N  = sit_pkg::SQRT_STEPS;
   localparam int unsigned DW = sit_pkg::RR_W;

   logic [DW-1:0] v_ff [0:N-1];
   logic [DW-1:0] v_in [0:N-1];
   logic [DW-1:0] r_ff [0:N-1];
   logic [DW-1:0] r_in [0:N-1];

   for (genvar s = 0; s < N; s++) begin : g_step
      localparam logic [DW-1:0] BIT = DW'(1) << (DW - 2 - 2 * s);
      logic [DW-1:0] v_src;
      logic [DW-1:0] r_src;
      logic [DW-1:0] trial;
      logic          ge;
      if (s == 0) begin : g_first
         assign v_src = rr_i;
         assign r_src = '0;
      end else begin : g_next
         assign v_src = v_ff[s-1];
         assign r_src = r_ff[s-1];
      end
      assign trial   = r_src + BIT;
      assign ge      = v_src >= trial;
      assign v_in[s] = ge ? (v_src - trial) : v_src;
      assign r_in[s] = ge ? ((r_src >> 1) + BIT) : (r_src >> 1);
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign root_o = r_ff[N-1][sit_pkg::DATA_W-1:0];

endmodule

@@ bench/tb_spherical_inversion_transform.sv @@
// Testbench of the spherical inversion core: random and corner points checked against a predictor
module tb_spherical_inversion_transform;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [31:0] x, y, z, de;
      logic        sat;
   } point_word_type;

   class inversion_scoreboard;
      longint         pre_x, pre_y, pre_z, post_x, post_y, post_z, scale;
      logic [127:0]   rsq;
      point_word_type pending_q[$];
      int             errors;

      function new();
         pre_x = 0; pre_y = 0; pre_z = 0; post_x = 0; post_y = 0; post_z = 0;
         rsq = 128'h10_0000;
         scale = 64'h10_0000;
         errors = 0;
      endfunction

      function void set_reg(sit_pkg::csr_reg_type idx, logic [31:0] v);
         case (idx)
            sit_pkg::REG_PRE_X:       pre_x = longint'(signed'(v));
            sit_pkg::REG_PRE_Y:       pre_y = longint'(signed'(v));
            sit_pkg::REG_PRE_Z:       pre_z = longint'(signed'(v));
            sit_pkg::REG_POST_X:      post_x = longint'(signed'(v));
            sit_pkg::REG_POST_Y:      post_y = longint'(signed'(v));
            sit_pkg::REG_POST_Z:      post_z = longint'(signed'(v));
            sit_pkg::REG_RADIUS_SQ:   rsq = {96'b0, v};
            sit_pkg::REG_FINAL_SCALE: scale = longint'(signed'(v));
            default: ;
         endcase
      endfunction

      function longint clamp_signed(bit neg, logic [127:0] m, inout bit f);
         if (!neg) begin
            if (m > 128'h7FFF_FFFF) begin f = 1; m = 128'h7FFF_FFFF; end
            return longint'(m[63:0]);
         end
         if (m > 128'h8000_0000) begin f = 1; m = 128'h8000_0000; end
         return -longint'(m[63:0]);
      endfunction

      function longint sum_sat(longint a, longint b, inout bit f);
         longint s;
         s = a + b;
         if (s > 64'sh7FFF_FFFF) begin f = 1; return 64'sh7FFF_FFFF; end
         if (s < -64'sh8000_0000) begin f = 1; return -64'sh8000_0000; end
         return s;
      endfunction

      function logic [127:0] magnitude(longint v);
         return {64'b0, (v < 0) ? -v : v};
      endfunction

      function longint invert(longint p, logic [127:0] rr, inout bit f);
         logic [127:0] q;
         q = ((magnitude(p) * rsq) << 20) / rr;
         if (q > 128'h8000_0001) begin f = 1; q = 128'h8000_0001; end
         return clamp_signed(p < 0, q, f);
      endfunction

      function longint rescale(longint c, inout bit f);
         return clamp_signed((c < 0) != (scale < 0), (magnitude(c) * magnitude(scale)) >> 20, f);
      endfunction

      function point_word_type transform(logic [31:0] ix, iy, iz, ide, bit ap);
         point_word_type r;
         longint         x, y, z;
         logic [127:0]   rr, root, trial, t, q, m;
         bit             f;
         f = 0;
         if (!ap) begin
            r.x = ix; r.y = iy; r.z = iz; r.de = ide; r.sat = 0;
            return r;
         end
         x = sum_sat(longint'(signed'(ix)), pre_x, f);
         y = sum_sat(longint'(signed'(iy)), pre_y, f);
         z = sum_sat(longint'(signed'(iz)), pre_z, f);
         rr = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y)
            + magnitude(z) * magnitude(z);
         if (rr == 0) begin
            r.x = sit_pkg::POS_MAX; r.y = sit_pkg::POS_MAX; r.z = sit_pkg::POS_MAX;
            r.de = 32'hFFFF_FFFF; r.sat = 1;
            return r;
         end
         root = 0;
         for (int i = 31; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (trial * trial <= rr) root = trial;
         end
         x = sum_sat(invert(x, rr, f), post_x, f);
         y = sum_sat(invert(y, rr, f), post_y, f);
         z = sum_sat(invert(z, rr, f), post_z, f);
         t = root * {96'b0, ide} + (rsq << 16);
         q = ((t * {96'b0, ide}) << 4) / rr;
         if (q > 128'hFFFF_FFFF) begin f = 1; q = 128'hFFFF_FFFF; end
         x = rescale(x, f);
         y = rescale(y, f);
         z = rescale(z, f);
         m = (q * magnitude(scale)) >> 20;
         if (scale < 0 && m != 0) begin f = 1; m = 0; end
         if (m > 128'hFFFF_FFFF) begin f = 1; m = 128'hFFFF_FFFF; end
         r.x = x[31:0]; r.y = y[31:0]; r.z = z[31:0]; r.de = m[31:0]; r.sat = f;
         return r;
      endfunction

      function void note_word(logic [31:0] ix, iy, iz, ide, bit ap);
         pending_q.push_back(transform(ix, iy, iz, ide, ap));
      endfunction

      function void check_word(point_word_type got);
         point_word_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result x=%h y=%h z=%h de=%h sat=%b",
                                       got.x, got.y, got.z, got.de, got.sat);
            return;
         end
         want = pending_q.pop_front();
         if (got != want) begin
            errors++;
            if (errors <= 10)
               $display("expected x=%h y=%h z=%h de=%h sat=%b, got x=%h y=%h z=%h de=%h sat=%b",
                        want.x, want.y, want.z, want.de, want.sat,
                        got.x, got.y, got.z, got.de, got.sat);
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic        clock, reset, start, busy, req_apply, rsp_strobe, rsp_saturated, csr_we;
   logic [31:0] req_in_x, req_in_y, req_in_z, req_in_de;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_de, csr_wdata;
   logic [sit_pkg::CSR_IDX_W-1:0] csr_index;
   inversion_scoreboard  sb;
   int                   idle_cycles;
   bit                   no_gaps;

   spherical_inversion_transform dut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_word(req_in_x, req_in_y, req_in_z, req_in_de, req_apply);
         if (rsp_strobe)
            sb.check_word('{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_de, rsp_saturated});
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("spherical_inversion_transform: mismatch");
            $finish;
         end
      end
   end

   task automatic write_reg(sit_pkg::csr_reg_type idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic configure(logic [31:0] px, py, pz, qx, qy, qz, rs, fs);
      while (sb.pending() != 0) @(posedge clock);
      write_reg(sit_pkg::REG_PRE_X, px);
      write_reg(sit_pkg::REG_PRE_Y, py);
      write_reg(sit_pkg::REG_PRE_Z, pz);
      write_reg(sit_pkg::REG_POST_X, qx);
      write_reg(sit_pkg::REG_POST_Y, qy);
      write_reg(sit_pkg::REG_POST_Z, qz);
      write_reg(sit_pkg::REG_RADIUS_SQ, rs);
      write_reg(sit_pkg::REG_FINAL_SCALE, fs);
      csr_we <= 1'b0;
   endtask

   task automatic send_word(logic [31:0] x, y, z, de, bit ap);
      int g;
      int r;
      r = $urandom_range(0, 99);
      g = (no_gaps || r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
      start <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_in_de <= de;
      req_apply <= ap;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0, 1: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         2: return $urandom;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h0;
               1: return 32'h1;
               2: return 32'hFFFF_FFFF;
               3: return sit_pkg::POS_MAX;
               default: return sit_pkg::NEG_MAX;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_de();
      case ($urandom_range(0, 3))
         0, 1: return $urandom_range(0, 32'h0004_0000);
         2: return $urandom;
         default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic random_words(int n);
      bit ap;
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         ap = ($urandom_range(0, 99) < 85);
         if (ap && $urandom_range(0, 29) == 0)
            send_word(-sb.pre_x, -sb.pre_y, -sb.pre_z, rand_de(), 1'b1);
         else
            send_word(rand_coord(), rand_coord(), rand_coord(), rand_de(), ap);
      end
      no_gaps = 0;
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_small();
      return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
   endfunction

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      req_in_de = '0;
      req_apply = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_cycles = 0;
      no_gaps = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(sit_pkg::POS_MAX, sit_pkg::NEG_MAX, 32'h0, 32'hFFFF_FFFF, 1'b0);
      send_word(sit_pkg::NEG_MAX, sit_pkg::POS_MAX, 32'hFFFF_FFFF, 32'h0, 1'b0);
      send_word(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
      send_word(sit_pkg::ONE, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
      send_word(32'h0, 32'hFFF0_0000, 32'h0, 32'h0, 1'b1);
      send_word(sit_pkg::POS_MAX, sit_pkg::POS_MAX, sit_pkg::POS_MAX, 32'hFFFF_FFFF, 1'b1);
      send_word(sit_pkg::NEG_MAX, sit_pkg::NEG_MAX, sit_pkg::NEG_MAX, 32'hFFFF_FFFF, 1'b1);
      send_word(32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
      send_word(32'h0, 32'h0, sit_pkg::NEG_MAX, 32'h1, 1'b1);
      random_words(240);

      configure(rand_small(), rand_small(), rand_small(), rand_small(), rand_small(),
                rand_small(), $urandom, $urandom_range(0, 32'h0040_0000));
      random_words(240);

      configure(sit_pkg::POS_MAX, sit_pkg::POS_MAX, sit_pkg::POS_MAX,
                sit_pkg::NEG_MAX, sit_pkg::NEG_MAX, sit_pkg::NEG_MAX,
                32'hFFFF_FFFF, sit_pkg::NEG_MAX);
      send_word(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      send_word(sit_pkg::NEG_MAX, sit_pkg::NEG_MAX, sit_pkg::NEG_MAX, 32'h0001_0000, 1'b1);
      send_word(32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 32'h0, 1'b1);
      random_words(200);

      configure(sit_pkg::NEG_MAX, sit_pkg::NEG_MAX, sit_pkg::NEG_MAX,
                sit_pkg::POS_MAX, sit_pkg::POS_MAX, sit_pkg::POS_MAX,
                32'h0, sit_pkg::POS_MAX);
      send_word(sit_pkg::POS_MAX, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
      random_words(200);

      configure(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, sit_pkg::ONE, 32'hFFF0_0000);
      send_word(sit_pkg::ONE, sit_pkg::ONE, 32'h0, 32'h0, 1'b1);
      send_word(sit_pkg::ONE, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
      send_word(32'hFFF0_0000, 32'h0, sit_pkg::ONE, 32'h0, 1'b1);
      random_words(240);

      configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_words(240);

      configure(rand_small(), rand_small(), rand_small(), rand_small(), rand_small(),
                rand_small(), $urandom_range(0, 32'h0100_0000),
                32'h0 - $urandom_range(0, sit_pkg::ONE));
      random_words(240);

      while (sb.pending() != 0) @(posedge clock);
      repeat (sit_pkg::LATENCY + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("spherical_inversion_transform: match");
      else
         $display("spherical_inversion_transform: mismatch");
      $finish;
   end
endmodule
